// ===== rtl/sdta_pkg.sv =====
// ----------------------------------------------------------------------------
// sdta_pkg: shared types and helpers for the segment descriptor table
// Table size, action codes, sequencer states and descriptor pack/decode.
// ----------------------------------------------------------------------------
package sdta_pkg;

	// Number of descriptor entries; entry 0 is never handed out.
	localparam int ENTRIES   = 32;
	localparam int IDX_W     = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	// Selector bits that form the entry index (selector >> 3).
	localparam int SEL_W     = 16;
	localparam int SEL_IDX_W = SEL_W - 3;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} act_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Update of one used bit.
	typedef struct packed {
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic             val;
	} used_upd_t;

	// Result of the free-entry search.
	typedef struct packed {
		logic             full;
		logic [IDX_W-1:0] idx;
	} free_srch_t;

	// Descriptor layout: limit 15..0 in bits 15..0, limit 19..16 in bits 51..48,
	// base 23..0 in bits 39..16, base 31..24 in bits 63..56.
	function automatic logic [63:0] pack_desc(input logic [31:0] base,
		input logic [19:0] limit, input logic [63:0] attr);
		pack_desc = attr | {base[31:24], 4'h0, limit[19:16], 8'h00,
			base[23:0], limit[15:0]};
	endfunction

	function automatic logic [31:0] decode_base(input logic [63:0] w);
		decode_base = {w[63:56], w[39:16]};
	endfunction

	function automatic logic [19:0] decode_limit(input logic [63:0] w);
		decode_limit = {w[51:48], w[15:0]};
	endfunction

endpackage

// ===== rtl/sdta_if.sv =====
// ----------------------------------------------------------------------------
// sdta_if: channel interfaces of the segment descriptor table
// Command channel and response channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------
interface sdta_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] seg_base;
	logic [19:0] seg_limit;
	logic [63:0] attr_bits;
	logic [15:0] sel_in;

	modport source (output valid, action, seg_base, seg_limit, attr_bits, sel_in,
		input ready);
	modport sink (input valid, action, seg_base, seg_limit, attr_bits, sel_in,
		output ready);
endinterface

interface sdta_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] sel_out;
	logic        status;
	logic [63:0] desc_word;
	logic [31:0] base_out;
	logic [19:0] limit_out;

	modport source (output valid, sel_out, status, desc_word, base_out, limit_out,
		input ready);
	modport sink (input valid, sel_out, status, desc_word, base_out, limit_out,
		output ready);
endinterface

// ===== rtl/sdta_ram.sv =====
// ----------------------------------------------------------------------------
// sdta_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdta_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/sdta_used.sv =====
// ----------------------------------------------------------------------------
// sdta_used: used-bit vector and free-entry search
// Keeps one bit per entry, set while the stored word is nonzero, and finds
// the lowest free entry from index 1 upward.
// ----------------------------------------------------------------------------
module sdta_used
	import sdta_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  used_upd_t        upd,
	input  logic [IDX_W-1:0] qidx,
	output logic             qused,
	output free_srch_t       srch
);

	logic [ENTRIES-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (upd.wr) begin
			used_q[upd.idx] <= upd.val;
		end
	end

	assign qused = used_q[qidx];

	// Priority encoder: scanning downward leaves the lowest free index.
	always_comb begin
		srch.full = 1'b1;
		srch.idx  = '0;
		for (int i = ENTRIES - 1; i >= 1; i--) begin
			if (!used_q[i]) begin
				srch.full = 1'b0;
				srch.idx  = IDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/segment_descriptor_table_allocator.sv =====
// ----------------------------------------------------------------------------
// segment_descriptor_table_allocator: x86 segment descriptor slot allocator
// Allocates, frees and reads 64-bit descriptors kept in an on-chip table.
// ----------------------------------------------------------------------------
// Usage:
// A command word on cmd carries an action (allocate, free, read or no
// operation), a base, a limit and flag bits for allocate, and a selector for
// free and read. Every command word yields exactly one response word on rsp:
// the allocated selector and a full status, or the stored descriptor with its
// decoded base and limit, with unused fields zero.
// In the cycle a command is accepted the used-bit search runs, the descriptor
// memory read is issued and, for allocate, the memory write too; in the
// execute state the registered read data is decoded and the response is
// loaded into the output register once that register is free. No new command
// is accepted until the previous response has been loaded.
// Reset clears the used bits at once; an entry whose used bit is clear reads
// as zero, so the table reads all zero after reset with no clearing pass.
// When the receiver stalls, the response stays in the output register; the
// next command is still accepted and waits in the execute state until the
// output register frees up.
// ----------------------------------------------------------------------------
module segment_descriptor_table_allocator
	import sdta_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	sdta_cmd_if.sink  cmd,
	sdta_rsp_if.source rsp
);

	state_t state_q, state_d;

	logic                 accept;
	act_t                 act;
	logic [SEL_IDX_W-1:0] sel_idx;
	logic                 in_range;
	logic [63:0]          packed_word;

	used_upd_t            upd;
	free_srch_t           srch;
	logic                 qused;
	logic                 ram_we;
	logic [63:0]          rdata;

	// Command state held for the execute state.
	act_t                 act_s1;
	logic                 in_range_s1;
	logic                 used_s1;
	free_srch_t           srch_s1;

	logic                 load_out;
	logic                 rsp_valid_q;
	logic [15:0]          sel_d;
	logic                 status_d;
	logic [63:0]          word_d;

	assign accept   = cmd.valid && cmd.ready;
	assign act      = act_t'(cmd.action);
	assign sel_idx  = cmd.sel_in[SEL_W-1:3];
	// One extra bit keeps the compare correct when the table fills the index.
	assign in_range = {1'b0, sel_idx} < (SEL_IDX_W + 1)'(ENTRIES);
	assign packed_word = pack_desc(cmd.seg_base, cmd.seg_limit, cmd.attr_bits);

	// Free entries are found in the used-bit vector; an allocation of a zero
	// word is stored but leaves the entry free.
	always_comb begin
		upd.wr  = 1'b0;
		upd.idx = srch.idx;
		upd.val = 1'b0;
		ram_we  = 1'b0;
		if (accept) begin
			unique case (act) inside
				ACT_ALLOC: begin
					upd.wr  = !srch.full;
					upd.val = packed_word != 64'd0;
					ram_we  = !srch.full;
				end
				ACT_FREE: begin
					upd.wr  = in_range;
					upd.idx = sel_idx[IDX_W-1:0];
				end
				ACT_READ, ACT_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	sdta_used u_used (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.qidx   (sel_idx[IDX_W-1:0]),
		.qused  (qused),
		.srch   (srch)
	);

	sdta_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (64),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (srch.idx),
		.wdata (packed_word),
		.re    (accept),
		.raddr (sel_idx[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= act;
			in_range_s1 <= in_range;
			used_s1     <= qused;
			srch_s1     <= srch;
		end
	end

	// Sequencer: idle until a command arrives, then execute until the response is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				load_out = !rsp_valid_q || rsp.ready;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Response fields; a never-used or freed entry reads as zero.
	always_comb begin
		sel_d    = '0;
		status_d = 1'b0;
		word_d   = '0;
		case (act_s1)
			ACT_ALLOC: begin
				status_d = srch_s1.full;
				if (!srch_s1.full) begin
					sel_d = 16'({srch_s1.idx, 3'b000});
				end
			end
			ACT_READ: begin
				if (in_range_s1 && used_s1) begin
					word_d = rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp.sel_out   <= sel_d;
			rsp.status    <= status_d;
			rsp.desc_word <= word_d;
			rsp.base_out  <= decode_base(word_d);
			rsp.limit_out <= decode_limit(word_d);
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

// ===== rtl/sdta_chk.sv =====
// ----------------------------------------------------------------------------
// sdta_chk: port-level checks for the segment descriptor table
// Watches the command and response channels of the top level.
// ----------------------------------------------------------------------------
module sdta_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] sel_out,
	input logic        status,
	input logic [63:0] desc_word,
	input logic [19:0] limit_out
);

	// A response is held until the receiver takes it.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One command at a time: no command is taken in the cycle after one.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted back to back");

	// A full table returns selector zero.
	a_full_sel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> sel_out == 16'd0)
		else $error("nonzero selector with full status");

	// The decoded limit always matches the returned descriptor.
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> limit_out == {desc_word[51:48], desc_word[15:0]})
		else $error("limit does not match descriptor");

endmodule

bind segment_descriptor_table_allocator sdta_chk u_sdta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.sel_out   (rsp.sel_out),
	.status    (rsp.status),
	.desc_word (rsp.desc_word),
	.limit_out (rsp.limit_out)
);

// ===== dv/segment_descriptor_table_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// segment_descriptor_table_allocator_tb: self-checking bench for the GDT slot allocator
// Walks a short table of directed commands and then runs shaped random
// command sequences. Idle gaps and stalls are random on both channels. A
// shadow copy of the descriptor table predicts the response words that the
// directed rows do not fix; every word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module segment_descriptor_table_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdta_pkg::*;

	localparam int          CLK_PERIOD   = 10;
	localparam int          RANDOM_ITEMS = 950;
	localparam int          HOLD_CYCLES  = 120;
	localparam int          DRAIN_LIMIT  = 2000;
	localparam int          TAIL_CYCLES  = 8;
	localparam int unsigned RUN_LIMIT_NS = 2_000_000;
	localparam int          MAX_REPORTS  = 10;

	// One command word as the bench sees it.
	typedef struct packed {
		act_t        action;
		logic [31:0] base;
		logic [19:0] limit;
		logic [63:0] attr;
		logic [15:0] sel;
	} seg_cmd_t;

	// One response word.
	typedef struct packed {
		logic [15:0] sel;
		logic        full;
		logic [63:0] desc;
		logic [31:0] base;
		logic [19:0] limit;
	} seg_rsp_t;

	// A row of the directed table. When typed is set, want is the response
	// read straight off the spec; otherwise the shadow table supplies it.
	typedef struct {
		seg_cmd_t cmd;
		bit       typed;
		seg_rsp_t want;
	} dir_row_t;

	localparam seg_rsp_t RSP_ZERO = '0;
	// Entry packed from an all-ones base and limit with no flag bits.
	localparam seg_rsp_t RSP_ONES_PACKED =
		'{16'h0000, 1'b0, 64'hFF0F_00FF_FFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF};
	// Entry whose flag bits alone set every bit of the word.
	localparam seg_rsp_t RSP_ONES_ATTR =
		'{16'h0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF};
	localparam seg_rsp_t RSP_SEL_1 = '{16'h0008, 1'b0, 64'h0, 32'h0, 20'h0};
	localparam seg_rsp_t RSP_SEL_2 = '{16'h0010, 1'b0, 64'h0, 32'h0, 20'h0};

	logic clk = 1'b0;
	logic arst_n;

	sdta_cmd_if cmd_ch ();
	sdta_rsp_if rsp_ch ();

	segment_descriptor_table_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the descriptor store and its used bits, cleared like reset.
	logic [63:0] shadow_desc [ENTRIES];
	bit          shadow_used [ENTRIES];

	// Predicted response words, oldest first.
	seg_rsp_t    expected_rsp_q [$];

	// Outcome of the most recent allocate, for read-back and fill sequences.
	logic [15:0] last_alloc_sel;
	bit          last_alloc_full;

	// Coordination between the command side and the response side.
	bit          hold_request;
	int unsigned cmd_calm_left;

	int unsigned n_items, n_alloc, n_full, n_zero_alloc, n_free, n_read, n_nop;
	int unsigned n_rsp, n_errors, n_reported, n_backpressure, n_holds;

	// The directed part: after-reset reads, extreme packings, the zero
	// descriptor that leaves its entry free, ignored selector low bits,
	// freeing entry 0, selectors past the end of the store and the unused
	// action code. Rows with a mixed payload are left to the shadow table.
	dir_row_t dir_rows [26] = '{
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0000}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1, RSP_ZERO},
		'{'{ACT_ALLOC, 32'h0000_0000, 20'h0_0000, 64'h0, 16'h0000}, 1'b1, RSP_SEL_1},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1, RSP_ZERO},
		'{'{ACT_ALLOC, 32'hFFFF_FFFF, 20'hF_FFFF, 64'h0, 16'h0000}, 1'b1, RSP_SEL_1},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1,
			RSP_ONES_PACKED},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h000F}, 1'b1,
			RSP_ONES_PACKED},
		'{'{ACT_ALLOC, 32'h0000_0000, 20'h0_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000},
			1'b1, RSP_SEL_2},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0010}, 1'b1, RSP_ONES_ATTR},
		'{'{ACT_ALLOC, 32'h1234_5678, 20'hA_BCDE, 64'h0000_9A00_0000_0000, 16'h0000},
			1'b0, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0018}, 1'b0, RSP_ZERO},
		'{'{ACT_ALLOC, 32'h89AB_CDEF, 20'h0_0000, 64'h0040_0000_0000_0000, 16'h0000},
			1'b0, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0021}, 1'b0, RSP_ZERO},
		'{'{ACT_FREE,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0010}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0010}, 1'b1, RSP_ZERO},
		'{'{ACT_ALLOC, 32'hA5A5_A5A5, 20'h5_A5A5, 64'h0, 16'h0000}, 1'b0, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0010}, 1'b0, RSP_ZERO},
		'{'{ACT_FREE,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0000}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0000}, 1'b1, RSP_ZERO},
		'{'{ACT_FREE,  32'h0000_0000, 20'h0_0000, 64'h0, 16'hFFFF}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'hFFF8}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0100}, 1'b1, RSP_ZERO},
		'{'{ACT_NOP,   32'hFFFF_FFFF, 20'hF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF},
			1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1,
			RSP_ONES_PACKED},
		'{'{ACT_FREE,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1, RSP_ZERO},
		'{'{ACT_READ,  32'h0000_0000, 20'h0_0000, 64'h0, 16'h0008}, 1'b1, RSP_ZERO}
	};

	// Applies one accepted command word to the shadow table and returns the
	// response word the block must give for it.
	function automatic seg_rsp_t predict_descriptor_rsp(input seg_cmd_t c);
		seg_rsp_t    r;
		logic [63:0] w;
		int unsigned slot;
		int unsigned idx;
		r   = '0;
		idx = c.sel >> 3;
		case (c.action)
			ACT_ALLOC: begin
				n_alloc++;
				// Lowest free entry from index 1 upward.
				slot = 1;
				while (slot < ENTRIES && shadow_used[slot])
					slot++;
				if (slot >= ENTRIES) begin
					r.full          = 1'b1;
					last_alloc_full = 1'b1;
					n_full++;
				end else begin
					w          = c.attr;
					w[15:0]    = w[15:0]  | c.limit[15:0];
					w[51:48]   = w[51:48] | c.limit[19:16];
					w[39:16]   = w[39:16] | c.base[23:0];
					w[63:56]   = w[63:56] | c.base[31:24];
					shadow_desc[slot] = w;
					// A zero word is stored but the entry stays free.
					shadow_used[slot] = (w != 64'h0);
					if (w == 64'h0)
						n_zero_alloc++;
					r.sel           = 16'(slot << 3);
					last_alloc_sel  = r.sel;
					last_alloc_full = 1'b0;
				end
			end
			ACT_FREE: begin
				n_free++;
				if (idx < ENTRIES) begin
					shadow_desc[idx] = 64'h0;
					shadow_used[idx] = 1'b0;
				end
			end
			ACT_READ: begin
				n_read++;
				if (idx < ENTRIES) begin
					w       = shadow_desc[idx];
					r.desc  = w;
					r.base  = {w[63:56], w[39:16]};
					r.limit = {w[51:48], w[15:0]};
				end
			end
			default: n_nop++;
		endcase
		return r;
	endfunction

	// Random 32-bit value that hits both extremes now and then.
	function automatic logic [31:0] pick32();
		int unsigned m;
		m = $urandom_range(0, 7);
		if (m == 0)
			return 32'h0;
		if (m == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Allocate word with random content. Flag bits are usually empty or
	// limited to the access byte and the flags nibble, and sometimes anything.
	function automatic seg_cmd_t rand_alloc();
		seg_cmd_t    c;
		int unsigned m;
		c.action = ACT_ALLOC;
		c.base   = pick32();
		c.limit  = 20'(pick32());
		c.sel    = 16'($urandom);
		m        = $urandom_range(0, 9);
		if (m < 4)
			c.attr = 64'h0;
		else if (m < 7)
			c.attr = {8'h00, 4'($urandom), 4'h0, 8'($urandom), 40'h0};
		else if (m < 9)
			c.attr = {$urandom, $urandom};
		else
			c.attr = 64'hFFFF_FFFF_FFFF_FFFF;
		return c;
	endfunction

	// Index of a random entry that holds a descriptor, or of any entry
	// past 0 when none does.
	function automatic int unsigned pick_live_idx();
		int unsigned live [$];
		for (int unsigned i = 1; i < ENTRIES; i++)
			if (shadow_used[i])
				live.push_back(i);
		if (live.size() == 0)
			return $urandom_range(1, ENTRIES - 1);
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	// Offers one command word and waits until it is taken. The expected
	// response is queued at the edge of acceptance. Valid is lowered only
	// when a gap follows, so back-to-back words keep it high throughout.
	task automatic send_cmd(input seg_cmd_t c, input bit typed, input seg_rsp_t want);
		int unsigned gap;
		seg_rsp_t    pred;
		if (cmd_calm_left > 0) begin
			gap = 0;
			cmd_calm_left--;
		end else begin
			gap = $urandom_range(0, 9);
		end
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.action    <= c.action;
		cmd_ch.seg_base  <= c.base;
		cmd_ch.seg_limit <= c.limit;
		cmd_ch.attr_bits <= c.attr;
		cmd_ch.sel_in    <= c.sel;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			n_backpressure++;
			@(posedge clk);
		end
		pred = predict_descriptor_rsp(c);
		expected_rsp_q.push_back(typed ? want : pred);
		n_items++;
	endtask

	// Compares one accepted response word with the oldest expectation.
	task automatic check_rsp(input seg_rsp_t got);
		seg_rsp_t want;
		n_rsp++;
		if (expected_rsp_q.size() == 0) begin
			n_errors++;
			if (n_reported < MAX_REPORTS) begin
				n_reported++;
				$display("[%0t] unexpected response word: sel=%h full=%b desc=%h base=%h lim=%h",
					$realtime, got.sel, got.full, got.desc, got.base, got.limit);
			end
		end else begin
			want = expected_rsp_q.pop_front();
			if (got.sel !== want.sel || got.full !== want.full ||
				got.desc !== want.desc || got.base !== want.base ||
				got.limit !== want.limit) begin
				n_errors++;
				if (n_reported < MAX_REPORTS) begin
					n_reported++;
					$display("[%0t] response %0d mismatch:", $realtime, n_rsp);
					$display("  exp sel=%h full=%b desc=%h base=%h lim=%h",
						want.sel, want.full, want.desc, want.base, want.limit);
					$display("  got sel=%h full=%b desc=%h base=%h lim=%h",
						got.sel, got.full, got.desc, got.base, got.limit);
				end
			end
		end
	endtask

	// Response monitor. Outputs are sampled at the rising edge, before the
	// block's own updates for that edge land.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			check_rsp('{rsp_ch.sel_out, rsp_ch.status, rsp_ch.desc_word,
				rsp_ch.base_out, rsp_ch.limit_out});
	end

	// Response side. A fresh stall is drawn for every word; now and then a
	// run of words goes through with no stall at all. When the command side
	// asks for it, ready stays low for a long count of cycles so that the
	// block fills up and has to refuse further command words.
	initial begin : rsp_drain
		int unsigned stall;
		int unsigned calm_left;
		calm_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall        = HOLD_CYCLES;
				n_holds++;
			end else if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = $urandom_range(0, 9);
				if ($urandom_range(0, 19) == 0)
					calm_left = 25;
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	// Hard stop in case the handshake hangs.
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("segment_descriptor_table_allocator_tb NOT OK");
		$finish;
	end

	// Command side and end of run.
	initial begin : stimulus
		seg_cmd_t    c;
		int unsigned kind;
		int unsigned idx;
		int unsigned nfree;
		int unsigned waited;
		bit          pressure_done;

		for (int i = 0; i < ENTRIES; i++) begin
			shadow_desc[i] = 64'h0;
			shadow_used[i] = 1'b0;
		end
		last_alloc_sel  = '0;
		last_alloc_full = 1'b0;
		hold_request    = 1'b0;
		cmd_calm_left   = 0;
		pressure_done   = 1'b0;

		arst_n           <= 1'b0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.action    <= ACT_NOP;
		cmd_ch.seg_base  <= '0;
		cmd_ch.seg_limit <= '0;
		cmd_ch.attr_bits <= '0;
		cmd_ch.sel_in    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

		// Random part, built from short sequences that mean something to the
		// allocator, with a share of pure noise mixed in.
		while (n_items < $size(dir_rows) + RANDOM_ITEMS) begin
			if (!pressure_done && n_items >= $size(dir_rows) + 300) begin
				// Long receiver hold with the sender offering word after word.
				pressure_done = 1'b1;
				hold_request  = 1'b1;
				cmd_calm_left = 16;
			end else if (cmd_calm_left == 0 && $urandom_range(0, 6) == 0) begin
				cmd_calm_left = 20;
			end
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// Allocate, then read the new entry back with random low bits.
				send_cmd(rand_alloc(), 1'b0, RSP_ZERO);
				if (!last_alloc_full) begin
					c        = rand_alloc();
					c.action = ACT_READ;
					c.sel    = last_alloc_sel | 16'($urandom_range(0, 7));
					send_cmd(c, 1'b0, RSP_ZERO);
				end
			end else if (kind < 60) begin
				// Free a few live entries, reading each one afterward.
				nfree = $urandom_range(1, 4);
				repeat (nfree) begin
					idx      = pick_live_idx();
					c        = rand_alloc();
					c.action = ACT_FREE;
					c.sel    = 16'(idx << 3) | 16'($urandom_range(0, 7));
					send_cmd(c, 1'b0, RSP_ZERO);
					c.action = ACT_READ;
					send_cmd(c, 1'b0, RSP_ZERO);
				end
			end else if (kind < 75) begin
				// Read any entry of the store.
				c        = rand_alloc();
				c.action = ACT_READ;
				c.sel    = 16'($urandom_range(0, ENTRIES - 1) << 3) |
					16'($urandom_range(0, 7));
				send_cmd(c, 1'b0, RSP_ZERO);
			end else if (kind < 82) begin
				// Fill the store until allocate is refused, try once more,
				// then open up some room again.
				do
					send_cmd(rand_alloc(), 1'b0, RSP_ZERO);
				while (!last_alloc_full);
				send_cmd(rand_alloc(), 1'b0, RSP_ZERO);
				nfree = $urandom_range(4, 10);
				repeat (nfree) begin
					c        = rand_alloc();
					c.action = ACT_FREE;
					c.sel    = 16'(pick_live_idx() << 3);
					send_cmd(c, 1'b0, RSP_ZERO);
				end
			end else begin
				// Noise: any action code, selectors often far past the store.
				c        = rand_alloc();
				c.action = act_t'($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 0)
					c.sel = 16'($urandom_range(0, ENTRIES - 1) << 3) |
						16'($urandom_range(0, 7));
				send_cmd(c, 1'b0, RSP_ZERO);
			end
		end
		cmd_ch.valid <= 1'b0;

		// Let every expected word come out, then watch a few more cycles
		// for anything extra.
		waited = 0;
		while (expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			n_errors++;
			$display("%0d expected response words never arrived", expected_rsp_q.size());
		end

		$display("Covered %0d command words: %0d allocates (%0d refused as full, %0d zero words),",
			n_items, n_alloc, n_full, n_zero_alloc);
		$display("  %0d frees, %0d reads, %0d no-ops; %0d responses, %0d input stall cycles, %0d long holds",
			n_free, n_read, n_nop, n_rsp, n_backpressure, n_holds);
		if (n_errors == 0)
			$display("segment_descriptor_table_allocator_tb OK");
		else
			$display("segment_descriptor_table_allocator_tb NOT OK");
		$finish;
	end

endmodule
